/* rtl/escu_pkg.sv */
package escu_pkg;

	localparam int unsigned NumStages = 46;

	localparam logic [31:0] CFG_TEMP       = 32'd0;
	localparam logic [31:0] CFG_PRESS_LOW  = 32'd1;
	localparam logic [31:0] CFG_PRESS_HIGH = 32'd2;
	localparam logic [31:0] CFG_MIXED      = 32'd3;
	localparam logic [31:0] CFG_HUM        = 32'd4;

	localparam logic [31:0] HUM_MAX = 32'd419430400;

	typedef logic [31:0] word_t;

	function automatic word_t mulw(input word_t a, input word_t b);
		return a * b;
	endfunction

	function automatic word_t asr(input word_t x, input logic [4:0] n);
		return word_t'($signed(x) >>> n);
	endfunction

	function automatic word_t sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic word_t sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

/* rtl/escu_sample_if.sv */
interface escu_sample_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temp;
	logic [19:0] raw_press;
	logic [15:0] raw_hum;

	modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
	modport sink   (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

/* rtl/escu_result_if.sv */
interface escu_result_if;
	logic               valid;
	logic               ready;
	logic signed [24:0] temp_centideg;
	logic [31:0]        press_pascal;
	logic               press_invalid;
	logic [16:0]        hum_q10;

	modport source (output valid, temp_centideg, press_pascal, press_invalid, hum_q10,
		input ready);
	modport sink   (input valid, temp_centideg, press_pascal, press_invalid, hum_q10,
		output ready);
endinterface

/* rtl/escu_cfg_if.sv */
interface escu_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/env_sensor_compensation_unit.sv */
// channel   direction  words
// in_ch     sink       raw_temp, raw_press, raw_hum
// out_ch    source     temp_centideg, press_pascal, press_invalid, hum_q10
// cfg_ch    sink       index, data (coefficient register write)
//
// One word enters per cycle while out_ch does not stall; each word passes through the stage registers.
// The pressure divide is a 32-stage restoring divider, one quotient bit per stage.
// arst_n clears the valid bits and coefficient registers.
// A stall on out_ch while out_ch.valid is high holds every stage; in_ch.ready stays low while it lasts.
// cfg_ch is always ready and writes take effect at once.
module env_sensor_compensation_unit (
	input  logic          clk,
	input  logic          arst_n,
	escu_sample_if.sink   in_ch,
	escu_result_if.source out_ch,
	escu_cfg_if.sink      cfg_ch
);
	import escu_pkg::*;

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [47:0] mixed_q;
	logic [39:0] hum_coeffs_q;

	word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;

	logic                 en;
	logic [NumStages:1]   vld_s;

	logic [19:0] adcp_s [1:8];
	logic [15:0] adch_s [1:6];
	word_t tx_s1, td_s1, m_a_s2, m_dd_s2, ta_s3, m_b_s3, fine_s4;
	logic signed [24:0] temp_s [5:NumStages];
	word_t pa_s5, v_s5;
	word_t m_d_s6, m_p5_s6, m_p2_s6, m_h5_s6, m_h6_s6, m_h3_s6;
	word_t m_p6_s7, m_p3_s7, m_p5_s7, m_p2_s7, ha_s7, hb_s7, hd_s7;
	word_t pb_s8, pa2_s8, m_hbd_s8, ha_s8;
	word_t m_p1_s9, m_pn_s9, hb2_s9, ha_s9;
	word_t m_h2_s10, ha_s10, hb3_s11, ha_s11, hv_s12;
	word_t m_vv_s13, hv_s13, m_dh1_s14, hv_s14;
	logic [16:0] hum_s [15:NumStages];
	word_t rem_s [10:42];
	word_t quo_s [10:42];
	word_t num_s [10:42];
	word_t dvs_s [10:42];
	logic  inv_s [10:NumStages];
	logic  dbl_s [10:42];
	word_t rem_nx [11:42];
	logic  qb_nx [11:42];
	word_t pf_s43, pf_s44, dd_s44, m_p8_s44, pf_s45, m_p8_s45, m_p9_s45, press_s46;

	word_t tw_pn, hv_cl, hum_acc, tmp_fine;
	logic signed [35:0] t_ext, t_scl;
	logic signed [24:0] t_sat;
	word_t dvs_nx;

	assign t1 = {16'b0, temp_coeffs_q[15:0]};
	assign t2 = sx16(temp_coeffs_q[31:16]);
	assign t3 = sx16(temp_coeffs_q[47:32]);
	assign p1 = {16'b0, press_lo_q[15:0]};
	assign p2 = sx16(press_lo_q[31:16]);
	assign p3 = sx16(press_lo_q[47:32]);
	assign p4 = sx16(press_lo_q[63:48]);
	assign p5 = sx16(press_hi_q[15:0]);
	assign p6 = sx16(press_hi_q[31:16]);
	assign p7 = sx16(press_hi_q[47:32]);
	assign p8 = sx16(press_hi_q[63:48]);
	assign p9 = sx16(mixed_q[15:0]);
	assign h1 = {24'b0, mixed_q[23:16]};
	assign h2 = sx16(mixed_q[39:24]);
	assign h3 = {24'b0, mixed_q[47:40]};
	assign h4 = sx16(hum_coeffs_q[15:0]);
	assign h5 = sx16(hum_coeffs_q[31:16]);
	assign h6 = sx8(hum_coeffs_q[39:32]);

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_lo_q    <= '0;
			press_hi_q    <= '0;
			mixed_q       <= '0;
			hum_coeffs_q  <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				CFG_TEMP:       temp_coeffs_q <= cfg_ch.data[47:0];
				CFG_PRESS_LOW:  press_lo_q    <= cfg_ch.data;
				CFG_PRESS_HIGH: press_hi_q    <= cfg_ch.data;
				CFG_MIXED:      mixed_q       <= cfg_ch.data[47:0];
				CFG_HUM:        hum_coeffs_q  <= cfg_ch.data[39:0];
				default: ;
			endcase
		end
	end

	assign en          = !vld_s[NumStages] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NumStages-1:1], in_ch.valid};
		end
	end

	always_comb begin
		tmp_fine = fine_s4;
		t_ext = {{4{tmp_fine[31]}}, tmp_fine};
		t_scl = ((t_ext <<< 2) + t_ext + 36'sd128) >>> 8;
		if (t_scl > 36'sd16777215) begin
			t_sat = 25'sd16777215;
		end else if (t_scl < -36'sd16777216) begin
			t_sat = -25'sd16777216;
		end else begin
			t_sat = t_scl[24:0];
		end
		tw_pn  = asr(m_p1_s9, 5'd15);
		dvs_nx = tw_pn;
		hum_acc = hv_s14 - asr(m_dh1_s14, 5'd4);
		if (hum_acc[31]) begin
			hv_cl = '0;
		end else if (hum_acc > HUM_MAX) begin
			hv_cl = HUM_MAX;
		end else begin
			hv_cl = hum_acc;
		end
	end

	always_comb begin
		for (int k = 11; k <= 42; k++) begin
			logic [32:0] r;
			r = {rem_s[k-1], num_s[k-1][31]};
			if (r >= {1'b0, dvs_s[k-1]}) begin
				rem_nx[k] = 32'(r - {1'b0, dvs_s[k-1]});
				qb_nx[k]  = 1'b1;
			end else begin
				rem_nx[k] = r[31:0];
				qb_nx[k]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adcp_s[1] <= in_ch.raw_press;
			adch_s[1] <= in_ch.raw_hum;
			for (int k = 2; k <= 8; k++) adcp_s[k] <= adcp_s[k-1];
			for (int k = 2; k <= 6; k++) adch_s[k] <= adch_s[k-1];

			tx_s1   <= {15'b0, in_ch.raw_temp[19:3]} - {t1[30:0], 1'b0};
			td_s1   <= {16'b0, in_ch.raw_temp[19:4]} - t1;
			m_a_s2  <= mulw(tx_s1, t2);
			m_dd_s2 <= mulw(td_s1, td_s1);
			ta_s3   <= asr(m_a_s2, 5'd11);
			m_b_s3  <= mulw(asr(m_dd_s2, 5'd12), t3);
			fine_s4 <= ta_s3 + asr(m_b_s3, 5'd14);

			temp_s[5] <= t_sat;
			for (int k = 6; k <= NumStages; k++) temp_s[k] <= temp_s[k-1];
			pa_s5 <= asr(fine_s4, 5'd1) - 32'd64000;
			v_s5  <= fine_s4 - 32'd76800;

			m_d_s6  <= mulw(asr(pa_s5, 5'd2), asr(pa_s5, 5'd2));
			m_p5_s6 <= mulw(pa_s5, p5);
			m_p2_s6 <= mulw(p2, pa_s5);
			m_h5_s6 <= mulw(h5, v_s5);
			m_h6_s6 <= mulw(v_s5, h6);
			m_h3_s6 <= mulw(v_s5, h3);

			m_p6_s7 <= mulw(asr(m_d_s6, 5'd11), p6);
			m_p3_s7 <= mulw(p3, asr(m_d_s6, 5'd13));
			m_p5_s7 <= m_p5_s6;
			m_p2_s7 <= m_p2_s6;
			ha_s7   <= asr(({2'b0, adch_s[6], 14'b0} - {h4[11:0], 20'b0} - m_h5_s6)
				+ 32'd16384, 5'd15);
			hb_s7   <= asr(m_h6_s6, 5'd10);
			hd_s7   <= asr(m_h3_s6, 5'd11) + 32'd32768;

			pb_s8    <= asr(m_p6_s7 + {m_p5_s7[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'b0};
			pa2_s8   <= asr(asr(m_p3_s7, 5'd3) + asr(m_p2_s7, 5'd1), 5'd18);
			m_hbd_s8 <= mulw(hb_s7, hd_s7);
			ha_s8    <= ha_s7;

			m_p1_s9 <= mulw(32'd32768 + pa2_s8, p1);
			m_pn_s9 <= mulw((32'd1048576 - {12'b0, adcp_s[8]}) - asr(pb_s8, 5'd12), 32'd3125);
			hb2_s9  <= asr(m_hbd_s8, 5'd10) + 32'd2097152;
			ha_s9   <= ha_s8;

			dvs_s[10] <= dvs_nx;
			inv_s[10] <= (dvs_nx == '0);
			dbl_s[10] <= m_pn_s9[31];
			num_s[10] <= m_pn_s9[31] ? m_pn_s9 : {m_pn_s9[30:0], 1'b0};
			rem_s[10] <= '0;
			quo_s[10] <= '0;
			m_h2_s10  <= mulw(hb2_s9, h2);
			ha_s10    <= ha_s9;

			hb3_s11  <= asr(m_h2_s10 + 32'd8192, 5'd14);
			ha_s11   <= ha_s10;
			hv_s12   <= mulw(ha_s11, hb3_s11);
			m_vv_s13 <= mulw(asr(hv_s12, 5'd15), asr(hv_s12, 5'd15));
			hv_s13   <= hv_s12;
			m_dh1_s14 <= mulw(asr(m_vv_s13, 5'd7), h1);
			hv_s14   <= hv_s13;
			hum_s[15] <= hv_cl[28:12];
			for (int k = 16; k <= NumStages; k++) hum_s[k] <= hum_s[k-1];

			for (int k = 11; k <= 42; k++) begin
				rem_s[k] <= rem_nx[k];
				quo_s[k] <= {quo_s[k-1][30:0], qb_nx[k]};
				num_s[k] <= {num_s[k-1][30:0], 1'b0};
				dvs_s[k] <= dvs_s[k-1];
				dbl_s[k] <= dbl_s[k-1];
			end
			for (int k = 11; k <= NumStages; k++) inv_s[k] <= inv_s[k-1];

			pf_s43   <= dbl_s[42] ? {quo_s[42][30:0], 1'b0} : quo_s[42];
			dd_s44   <= mulw(pf_s43 >> 3, pf_s43 >> 3) >> 13;
			m_p8_s44 <= mulw(pf_s43 >> 2, p8);
			pf_s44   <= pf_s43;
			m_p9_s45 <= mulw(p9, dd_s44);
			m_p8_s45 <= m_p8_s44;
			pf_s45   <= pf_s44;
			press_s46 <= inv_s[45] ? '0 : pf_s45 + asr(asr(m_p9_s45, 5'd12)
				+ asr(m_p8_s45, 5'd13) + p7, 5'd4);
		end
	end

	assign out_ch.valid         = vld_s[NumStages];
	assign out_ch.temp_centideg = temp_s[NumStages];
	assign out_ch.press_pascal  = press_s46;
	assign out_ch.press_invalid = inv_s[NumStages];
	assign out_ch.hum_q10       = hum_s[NumStages];

`ifndef SYNTH
	a_ready_follows_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready)) else $error("ready mismatch");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.press_invalid |-> out_ch.press_pascal == '0)
		else $error("invalid pressure not zero");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.hum_q10 <= 17'd102400) else $error("humidity out of range");
	a_last_stage: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NumStages-1] && en |=> out_ch.valid) else $error("word lost at output");
`endif

endmodule

/* test/env_sensor_compensation_unit_test.sv */
`timescale 1ns / 1ps

module env_sensor_compensation_unit_test;
	import escu_pkg::*;

	typedef struct packed {
		logic signed [24:0] temp_centideg;
		logic [31:0]        press_pascal;
		logic               press_invalid;
		logic [16:0]        hum_q10;
	} reading_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   idle_cycles;
	int   hold_off;
	bit   done;

	logic [47:0] temp_reg;
	logic [63:0] press_lo_reg;
	logic [63:0] press_hi_reg;
	logic [47:0] mixed_reg;
	logic [39:0] hum_reg;

	reading_t pending_readings[$];

	escu_sample_if in_ch ();
	escu_result_if out_ch ();
	escu_cfg_if cfg_ch ();

	env_sensor_compensation_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [31:0] sra(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] se16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
		input logic [15:0] rh);
		logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
		logic [31:0] a, b, d, fine, p, v, adc_t, adc_p, adc_h;
		longint t;
		reading_t r;
		adc_t = {12'd0, rt};
		adc_p = {12'd0, rp};
		adc_h = {16'd0, rh};
		t1 = {16'd0, temp_reg[15:0]};
		t2 = se16(temp_reg[31:16]);
		t3 = se16(temp_reg[47:32]);
		p1 = {16'd0, press_lo_reg[15:0]};
		p2 = se16(press_lo_reg[31:16]);
		p3 = se16(press_lo_reg[47:32]);
		p4 = se16(press_lo_reg[63:48]);
		p5 = se16(press_hi_reg[15:0]);
		p6 = se16(press_hi_reg[31:16]);
		p7 = se16(press_hi_reg[47:32]);
		p8 = se16(press_hi_reg[63:48]);
		p9 = se16(mixed_reg[15:0]);
		h1 = {24'd0, mixed_reg[23:16]};
		h2 = se16(mixed_reg[39:24]);
		h3 = {24'd0, mixed_reg[47:40]};
		h4 = se16(hum_reg[15:0]);
		h5 = se16(hum_reg[31:16]);
		h6 = {{24{hum_reg[39]}}, hum_reg[39:32]};

		a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
		d = (adc_t >> 4) - t1;
		b = sra(sra(d * d, 12) * t3, 14);
		fine = a + b;
		t = longint'($signed(fine)) * 5 + 128;
		t = t >>> 8;
		if (t > 16777215) t = 16777215;
		if (t < -16777216) t = -16777216;
		r.temp_centideg = t[24:0];

		a = sra(fine, 1) - 32'd64000;
		d = sra(a, 2) * sra(a, 2);
		b = sra(d, 11) * p6;
		b = b + ((a * p5) << 1);
		b = sra(b, 2) + (p4 << 16);
		a = sra(sra(p3 * sra(d, 13), 3) + sra(p2 * a, 1), 18);
		a = sra((32'd32768 + a) * p1, 15);
		if (a == 0) begin
			r.press_invalid = 1'b1;
			p = 0;
		end else begin
			r.press_invalid = 1'b0;
			p = ((32'd1048576 - adc_p) - sra(b, 12)) * 32'd3125;
			if (p < 32'h80000000) p = (p << 1) / a;
			else p = (p / a) * 2;
			d = ((p >> 3) * (p >> 3)) >> 13;
			a = sra(p9 * d, 12);
			b = sra((p >> 2) * p8, 13);
			p = p + sra(a + b + p7, 4);
		end
		r.press_pascal = p;

		v = fine - 32'd76800;
		a = sra(((adc_h << 14) - (h4 << 20) - h5 * v) + 32'd16384, 15);
		b = sra(v * h6, 10);
		d = sra(v * h3, 11) + 32'd32768;
		b = sra(b * d, 10) + 32'd2097152;
		b = sra(b * h2 + 32'd8192, 14);
		v = a * b;
		d = sra(sra(v, 15) * sra(v, 15), 7);
		v = v - sra(d * h1, 4);
		if (v[31]) v = 0;
		if (v > HUM_MAX) v = HUM_MAX;
		r.hum_q10 = v[28:12];
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	task automatic write_reg(input logic [31:0] idx, input logic [63:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_TEMP:       temp_reg = val[47:0];
			CFG_PRESS_LOW:  press_lo_reg = val;
			CFG_PRESS_HIGH: press_hi_reg = val;
			CFG_MIXED:      mixed_reg = val[47:0];
			CFG_HUM:        hum_reg = val[39:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
		input logic [15:0] rh, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 8) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.raw_temp <= rt;
		in_ch.raw_press <= rp;
		in_ch.raw_hum <= rh;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_readings.push_back(compensate(rt, rp, rh));
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic load_coeffs(input logic [47:0] tc, input logic [63:0] pl,
		input logic [63:0] ph, input logic [47:0] mc, input logic [39:0] hc);
		write_reg(CFG_TEMP, {16'hFFFF, tc});
		write_reg(CFG_PRESS_LOW, pl);
		write_reg(CFG_PRESS_HIGH, ph);
		write_reg(CFG_MIXED, {16'hFFFF, mc});
		write_reg(CFG_HUM, {24'hFFFFFF, hc});
		write_reg(32'd5, 64'hDEAD_BEEF_0000_0001);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic load_typical();
		load_coeffs({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'hD0CC, 16'd3024, 16'd36477},
			{16'd15500, 16'hC6B0, 16'hFFF9, 16'd140}, {8'd0, 16'd362, 8'd75, 16'd6000},
			{8'd30, 16'd50, 16'd313});
	endtask

	task automatic test_reset_coeffs();
		send_sample(20'd0, 20'd0, 16'd0, 0);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
		drain();
	endtask

	task automatic test_directed();
		load_typical();
		send_sample(20'd519888, 20'd415148, 16'd32000, 0);
		send_sample(20'd0, 20'd0, 16'd0, 0);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
		send_sample(20'hFFFFF, 20'd0, 16'd0, 0);
		send_sample(20'd0, 20'hFFFFF, 16'hFFFF, 0);
		send_sample(20'h55555, 20'hAAAAA, 16'h5555, 0);
		send_sample(20'hAAAAA, 20'h55555, 16'hAAAA, 0);
		drain();
		load_coeffs({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, {48{1'b1}}, {40{1'b1}});
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
		send_sample(20'd0, 20'd0, 16'd0, 0);
		drain();
		load_coeffs({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
			{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, {8'hFF, 16'h7FFF, 8'hFF, 16'h8000},
			{8'h7F, 16'h8000, 16'h7FFF});
		send_sample(20'hFFFFF, 20'd0, 16'hFFFF, 0);
		send_sample(20'd0, 20'hFFFFF, 16'd0, 0);
		send_sample(20'd12345, 20'd54321, 16'd999, 0);
		drain();
	endtask

	task automatic random_phase(input int count);
		repeat (count) begin
			logic [19:0] rt;
			rt = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(400000, 600000));
			send_sample(rt, 20'($urandom), 16'($urandom), 1);
		end
	endtask

	task automatic test_random_typical();
		load_typical();
		random_phase(250);
		drain();
	endtask

	task automatic test_random_coeffs();
		repeat (6) begin
			load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom},
				{$urandom, $urandom}, 48'({$urandom, $urandom}), 40'({$urandom, $urandom}));
			random_phase(50);
			drain();
		end
	endtask

	task automatic test_backpressure();
		load_typical();
		hold_off = 150;
		repeat (80) send_sample(20'($urandom), 20'($urandom), 16'($urandom), 0);
		drain();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_readings.size() == 0) begin
				report("unexpected word", 0, 0);
			end else begin
				reading_t w;
				w = pending_readings.pop_front();
				if (out_ch.temp_centideg !== w.temp_centideg)
					report("temp_centideg", 32'(out_ch.temp_centideg), 32'(w.temp_centideg));
				if (out_ch.press_pascal !== w.press_pascal)
					report("press_pascal", out_ch.press_pascal, w.press_pascal);
				if (out_ch.press_invalid !== w.press_invalid)
					report("press_invalid", 32'(out_ch.press_invalid), 32'(w.press_invalid));
				if (out_ch.hum_q10 !== w.hum_q10)
					report("hum_q10", 32'(out_ch.hum_q10), 32'(w.hum_q10));
			end
		end
	end

	initial begin
		int wait_cycles;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ch.ready <= 1'b0;
				hold_off--;
			end else if (wait_cycles > 0) begin
				out_ch.ready <= 1'b0;
				wait_cycles--;
			end else begin
				out_ch.ready <= 1'b1;
				if (out_ch.valid && $urandom_range(0, 2) == 0) wait_cycles = $urandom_range(0, 8);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_ch.valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000 && !done) begin
			$display("env_sensor_compensation_unit_test NOT OK");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 0;
		done = 0;
		temp_reg = 0;
		press_lo_reg = 0;
		press_hi_reg = 0;
		mixed_reg = 0;
		hum_reg = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.raw_temp = 0;
		in_ch.raw_press = 0;
		in_ch.raw_hum = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = 0;
		cfg_ch.data = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_coeffs();
		test_directed();
		test_random_typical();
		test_random_coeffs();
		test_backpressure();
		done = 1;
		if (mismatches == 0 && pending_readings.size() == 0) begin
			$display("env_sensor_compensation_unit_test OK");
		end else begin
			$display("env_sensor_compensation_unit_test NOT OK");
		end
		$finish;
	end

endmodule
